// ===== hw/rtl/bsw_pkg.sv =====
// Shared types, constants and header byte lookup for the BMP stream writer.
package bsw_pkg;

    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 14;
    localparam int DIM_FIELD_W    = 16;
    localparam int ROWSZ_W        = 18;
    localparam int IDX_W          = 6;
    localparam int HDR_BYTES      = 14 + 40;
    localparam int INFO_BYTES     = 40;
    localparam int PELS_PER_METER = 11811;
    localparam int BITS_PER_PIXEL = 24;
    localparam logic [15:0] BMP_MAGIC = 16'h4D42;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_PIXEL  = 1'b1
    } t_kind;

    localparam logic FUNC_START = 1'b0;

    // One queued job for the byte serializer.
    typedef struct packed {
        t_kind                   kind;
        logic [DIM_FIELD_W-1:0]  width;
        logic [DIM_FIELD_W-1:0]  height;
        logic [ROWSZ_W-1:0]      rowsz;
        logic [7:0]              blue;
        logic [7:0]              green;
        logic [7:0]              red;
        logic [1:0]              pad_n;
        logic                    eof;
    } t_entry;

    function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] sel);
        logic [7:0] b;
        b = v[{sel, 3'b000} +: 8];
        return b;
    endfunction

    // Byte of the 54-byte header at a given offset. All 32-bit fields start at
    // an offset that is 2 mod 4, so the byte lane is the offset plus 2.
    function automatic logic [7:0] hdr_byte(
        input logic [IDX_W-1:0] idx,
        input logic [31:0]      filesz,
        input logic [31:0]      datasz,
        input logic [31:0]      w,
        input logic [31:0]      h
    );
        logic [1:0] sel;
        logic [7:0] b;
        sel = idx[1:0] + 2'd2;
        case (idx) inside
            6'd0:           b = BMP_MAGIC[7:0];
            6'd1:           b = BMP_MAGIC[15:8];
            [6'd2:6'd5]:    b = le_byte(filesz, sel);
            [6'd10:6'd13]:  b = le_byte(32'(HDR_BYTES), sel);
            [6'd14:6'd17]:  b = le_byte(32'(INFO_BYTES), sel);
            [6'd18:6'd21]:  b = le_byte(w, sel);
            [6'd22:6'd25]:  b = le_byte(h, sel);
            6'd26:          b = 8'd1;
            6'd28:          b = 8'(BITS_PER_PIXEL);
            [6'd34:6'd37]:  b = le_byte(datasz, sel);
            [6'd38:6'd45]:  b = le_byte(32'(PELS_PER_METER), sel);
            default:        b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/bsw_if.sv =====
// Stream channel interfaces: pixel items in, file bytes out.
interface bsw_pix_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, func, red, green, blue, input ready);
    modport sink   (input valid, func, red, green, blue, output ready);
endinterface

interface bsw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_of_run;
    logic       end_of_frame;

    modport source (output valid, byte_value, last_of_run, end_of_frame, input ready);
    modport sink   (input valid, byte_value, last_of_run, end_of_frame, output ready);
endinterface

// ===== hw/rtl/bsw_front.sv =====
// Front end: config registers, frame tracking and job classification.
module bsw_front
    import bsw_pkg::*;
#(
    parameter int MAX_DIM = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bsw_pix_if.sink               i_pix,
    output logic                  o_push_valid,
    output t_entry                o_push_data,
    input  logic                  i_push_ready
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [CFG_DATA_W-1:0] r_image_width, r_image_height;
    logic                  r_in_frame, n_in_frame;
    logic [DIM_W-1:0]      r_col, n_col, r_row, n_row;
    logic [DIM_W-1:0]      r_fw, n_fw, r_fh, n_fh;
    logic [DIM_W-1:0]      clamp_w, clamp_h, col_inc, row_inc;
    logic                  accept;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (17'(v) > 17'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    assign i_pix.ready = i_push_ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign clamp_w     = clamp_dim(r_image_width);
    assign clamp_h     = clamp_dim(r_image_height);
    assign col_inc     = r_col + DIM_W'(1);
    assign row_inc     = r_row + DIM_W'(1);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_col        = r_col;
        n_row        = r_row;
        n_fw         = r_fw;
        n_fh         = r_fh;
        o_push_valid = 1'b0;
        o_push_data  = '0;
        o_push_data.blue  = i_pix.blue;
        o_push_data.green = i_pix.green;
        o_push_data.red   = i_pix.red;
        if (accept) begin
            if (i_pix.func == FUNC_START) begin
                // latch frame geometry and queue the header
                n_fw       = clamp_w;
                n_fh       = clamp_h;
                n_col      = '0;
                n_row      = '0;
                n_in_frame = 1'b1;
                o_push_valid       = 1'b1;
                o_push_data.kind   = KIND_HEADER;
                o_push_data.width  = DIM_FIELD_W'(clamp_w);
                o_push_data.height = DIM_FIELD_W'(clamp_h);
                o_push_data.rowsz  = ((ROWSZ_W'(clamp_w) << 1) + ROWSZ_W'(clamp_w)
                                      + ROWSZ_W'(3)) & ~ROWSZ_W'(3);
            end else if (r_in_frame) begin
                o_push_valid     = 1'b1;
                o_push_data.kind = KIND_PIXEL;
                if (col_inc >= r_fw) begin
                    // row done: pad to four bytes, advance row
                    o_push_data.pad_n = r_fw[1:0];
                    n_col = '0;
                    n_row = row_inc;
                    if (row_inc >= r_fh) begin
                        o_push_data.eof = 1'b1;
                        n_in_frame = 1'b0;
                        n_row      = '0;
                    end
                end else begin
                    n_col = col_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_DATA_W'(1);
            r_image_height <= CFG_DATA_W'(1);
            r_in_frame     <= 1'b0;
            r_col          <= '0;
            r_row          <= '0;
            r_fw           <= DIM_W'(1);
            r_fh           <= DIM_W'(1);
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_IMAGE_HEIGHT) begin
                r_image_height <= i_cfg_data;
            end
            r_in_frame <= n_in_frame;
            r_col      <= n_col;
            r_row      <= n_row;
            r_fw       <= n_fw;
            r_fh       <= n_fh;
        end
    end

endmodule

// ===== hw/rtl/bsw_fifo.sv =====
// Small job queue between front end and serializer.
module bsw_fifo
    import bsw_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_data,
    output logic   o_not_full,
    input  logic   i_pop,
    output logic   o_not_empty,
    output t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/bsw_back.sv =====
// Back end: serializes queued jobs into file bytes through an output register.
module bsw_back
    import bsw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_entry    i_q_head,
    output logic      o_q_pop,
    bsw_byte_if.source o_byte
);

    t_entry            r_cur;
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx, last_idx;
    logic [31:0]       r_datasz, r_filesz;
    logic              r_out_valid, r_last, r_eof;
    logic [7:0]        r_byte, cur_byte;
    logic              slot_free, emit, fin;

    assign slot_free = !r_out_valid || o_byte.ready;
    assign emit      = r_busy && slot_free;
    assign last_idx  = (r_cur.kind == KIND_HEADER) ? IDX_W'(HDR_BYTES - 1)
                                                   : IDX_W'(2) + IDX_W'(r_cur.pad_n);
    assign fin       = emit && (r_idx == last_idx);
    assign o_q_pop   = i_q_valid && (!r_busy || fin);

    always_comb begin
        if (r_cur.kind == KIND_HEADER) begin
            cur_byte = hdr_byte(r_idx, r_filesz, r_datasz,
                                32'(r_cur.width), 32'(r_cur.height));
        end else begin
            case (r_idx)
                6'd0:    cur_byte = r_cur.blue;
                6'd1:    cur_byte = r_cur.green;
                6'd2:    cur_byte = r_cur.red;
                default: cur_byte = 8'd0;
            endcase
        end
    end

    // image size (r_datasz) and then file size (r_filesz) are registered from the
    // loaded header and settle before their first byte is reached
    always_ff @(posedge i_clk) begin
        r_datasz <= 32'(r_cur.rowsz * 34'(r_cur.height));
        r_filesz <= r_datasz + 32'(HDR_BYTES);
        if (o_q_pop) begin
            r_cur <= i_q_head;
        end
        if (emit) begin
            r_byte <= cur_byte;
            r_last <= (r_idx == last_idx);
            r_eof  <= (r_idx == last_idx) && (r_cur.kind == KIND_PIXEL) && r_cur.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (fin) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_byte.valid        = r_out_valid;
    assign o_byte.byte_value   = r_byte;
    assign o_byte.last_of_run  = r_last;
    assign o_byte.end_of_frame = r_eof;

endmodule

// ===== hw/rtl/bmp24_stream_writer.sv =====
// Top level of the 24-bit BMP byte stream writer.
//
// Usage: program image_width (index 0) and image_height (index 1) through the
// write port while idle; values are sampled at each frame start, 0 reads as 1
// and values above MAX_DIM read as MAX_DIM. Send a start item (func = 0) on
// i_pix to emit the 54-byte header, then pixel items (func = 1). Each pixel
// yields blue, green, red; the last pixel of a row adds width mod 4 zero bytes.
// Pixels outside a frame are dropped. o_byte carries one byte per transfer,
// with last_of_run on the final byte of each item and end_of_frame on the
// final byte of the file.
// Throughput: one byte per cycle while the receiver is ready, so a pixel is 3
// bytes (3 to 6 at a row end) and a header 54 bytes. Items pass the job queue
// and the serializer's job register before reaching the output register. The
// FIFO_DEPTH job queue lets the front end take items while the serializer works.
// Reset clears the frame state, counters, queue and output register and sets
// both dimensions to 1. When the receiver stalls, the output register holds
// its byte, the serializer stops and the queue fills before i_pix.ready drops.
module bmp24_stream_writer
    import bsw_pkg::*;
#(
    parameter int MAX_DIM    = 8192,
    parameter int FIFO_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bsw_pix_if.sink               i_pix,
    bsw_byte_if.source            o_byte
);

    logic   push_valid, push_ready;
    t_entry push_data;
    logic   q_valid, q_pop;
    t_entry q_head;

    // classify items, track column and row, hold dimensions
    bsw_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pix        (i_pix),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    // decouple front end from the byte serializer
    bsw_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_push_data (push_data),
        .o_not_full  (push_ready),
        .i_pop       (q_pop),
        .o_not_empty (q_valid),
        .o_head      (q_head)
    );

    // drain jobs one byte per cycle, while the receiver is ready, into the output register
    bsw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_byte    (o_byte)
    );

endmodule
